FILE: rtl/core/vtp_pkg.sv
// vtp_pkg: widths, register codes and shared types for the vertex transform.
// No dependencies.
`default_nettype none
package vtp_pkg;

    localparam int PT_W    = 32;            // Q16.16 coordinate
    localparam int COEF_W  = 16;            // Q4.12 coefficient
    localparam int ROW_W   = 4 * COEF_W;    // one matrix row register
    localparam int N_ROWS  = 4;
    localparam int N_COLS  = 4;
    localparam int PROD_W  = PT_W + COEF_W; // Q.28 product
    localparam int SUM_W   = 50;            // sum of four Q.28 terms
    localparam int TR_SH   = 16;            // Q4.12 -> Q.28 for the translation row
    localparam int FRAC_SH = 12;            // Q.28 -> Q16.16
    localparam int T_W     = 38;            // reduced x', y', z', w'
    localparam int MAG_W   = T_W + 16;      // |x'| * 2^16
    localparam int Q_W     = 32;            // quotient magnitude bits kept
    localparam int CMP_W   = T_W + Q_W;     // divisor shifted by up to Q_W
    localparam int CFG_IDX_W = 3;
    localparam int LAT     = 37;            // start to result strobe

    localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW3 = 3'd3;

    localparam logic [ROW_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;

    localparam logic signed [PT_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PT_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic [N_ROWS-1:0][ROW_W-1:0] t_matrix;

    // control that travels down the divider with each item
    typedef struct packed {
        logic neg;  // result sign
        logic wz;   // w' was zero
        logic ovf;  // quotient magnitude at least 2^32
    } t_div_ctl;

    typedef struct packed {
        logic wz;
        logic sat;
    } t_lane_flags;

endpackage
`default_nettype wire

FILE: rtl/core/vertex_transform_perspective.sv
// vertex_transform_perspective: top level, matrix registers and valid tracking.
// Depends on vtp_pkg, vtp_xform and vtp_div_lane.
`default_nettype none
// Homogeneous 4x4 vertex transform with perspective divide.
//
// Items: a point (x, y, z, Q16.16) is taken at each rising edge with start
// high and busy low. busy is never raised, so a point may be given every
// clock. The point times the matrix gives x', y', z', w'; x', y', z' are
// then divided by w' (truncating; passed through when w' is zero) and clamped to Q16.16.
//
// Pipeline from start to o_valid, one item per clock sustained:
//   multiply, then sum/reduce (twelve 32x16 multipliers)
//   magnitude split, then overflow check
//   restoring divider, one quotient bit per stage per lane
//   sign, clamp and output register
// Each result sits on the o_ ports for one cycle with o_valid high; the
// receiver cannot hold it off, so nothing stalls.
//
// Configuration: i_cfg_idx 0..3 writes matrix row 0..3 (row 3 translation),
// taken whenever i_cfg_valid is high; other indexes are ignored. The user must
// write rows only while no item is in flight; the block does not enforce it.
// Reset (synchronous, active low) loads the identity matrix and clears the
// valid pipe; items in flight are dropped.
module vertex_transform_perspective
    import vtp_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     start,
    output logic                    busy,
    input  wire signed [PT_W-1:0]   i_in_x,
    input  wire signed [PT_W-1:0]   i_in_y,
    input  wire signed [PT_W-1:0]   i_in_z,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [ROW_W-1:0]         i_cfg_data,
    output logic                    o_valid,
    output logic signed [PT_W-1:0]  o_out_x,
    output logic signed [PT_W-1:0]  o_out_y,
    output logic signed [PT_W-1:0]  o_out_z,
    output logic                    o_w_zero,
    output logic                    o_saturated
);

    t_matrix          r_m;
    logic [LAT-1:0]   r_vld;
    logic signed [T_W-1:0] t [N_COLS];
    t_lane_flags      fl_x, fl_y, fl_z;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // matrix row registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m[0] <= ROW0_RST;
            r_m[1] <= ROW1_RST;
            r_m[2] <= ROW2_RST;
            r_m[3] <= ROW3_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_idx)
                CFG_ROW0: r_m[0] <= i_cfg_data;
                CFG_ROW1: r_m[1] <= i_cfg_data;
                CFG_ROW2: r_m[2] <= i_cfg_data;
                CFG_ROW3: r_m[3] <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // valid bit shadows the item down the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    vtp_xform u_xform (
        .i_clk (i_clk),
        .i_x   (i_in_x),
        .i_y   (i_in_y),
        .i_z   (i_in_z),
        .i_m   (r_m),
        .o_t   (t)
    );

    vtp_div_lane u_lane_x (
        .i_clk (i_clk), .i_t (t[0]), .i_w (t[3]), .o_res (o_out_x), .o_flags (fl_x)
    );
    vtp_div_lane u_lane_y (
        .i_clk (i_clk), .i_t (t[1]), .i_w (t[3]), .o_res (o_out_y), .o_flags (fl_y)
    );
    vtp_div_lane u_lane_z (
        .i_clk (i_clk), .i_t (t[2]), .i_w (t[3]), .o_res (o_out_z), .o_flags (fl_z)
    );

    // all lanes see the same w', any one gives the zero flag
    assign o_valid     = r_vld[LAT-1];
    assign o_w_zero    = fl_x.wz & fl_y.wz & fl_z.wz;
    assign o_saturated = fl_x.sat | fl_y.sat | fl_z.sat;

endmodule
`default_nettype wire

FILE: rtl/core/vtp_xform.sv
// vtp_xform: two-stage 4x4 matrix product (multiply, then sum and reduce).
// Depends on vtp_pkg.
`default_nettype none
module vtp_xform
    import vtp_pkg::*;
(
    input  wire                     i_clk,
    input  wire signed [PT_W-1:0]   i_x,
    input  wire signed [PT_W-1:0]   i_y,
    input  wire signed [PT_W-1:0]   i_z,
    input  wire t_matrix            i_m,
    output logic signed [T_W-1:0]   o_t [N_COLS]
);

    logic signed [PROD_W-1:0] r_px [N_COLS];
    logic signed [PROD_W-1:0] r_py [N_COLS];
    logic signed [PROD_W-1:0] r_pz [N_COLS];
    logic signed [COEF_W-1:0] r_tr [N_COLS];
    logic signed [SUM_W-1:0]  n_sum [N_COLS];

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < N_COLS; c++) begin
            r_px[c] <= i_x * $signed(i_m[0][c*COEF_W +: COEF_W]);
            r_py[c] <= i_y * $signed(i_m[1][c*COEF_W +: COEF_W]);
            r_pz[c] <= i_z * $signed(i_m[2][c*COEF_W +: COEF_W]);
            r_tr[c] <= $signed(i_m[3][c*COEF_W +: COEF_W]);
        end
    end

    always_comb begin
        for (int c = 0; c < N_COLS; c++) begin
            n_sum[c] = SUM_W'(r_px[c]) + SUM_W'(r_py[c]) + SUM_W'(r_pz[c])
                     + (SUM_W'(r_tr[c]) <<< TR_SH);
        end
    end

    // arithmetic shift: floor to Q16.16
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < N_COLS; c++) begin
            o_t[c] <= T_W'(n_sum[c] >>> FRAC_SH);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/vtp_div_stage.sv
// vtp_div_stage: one restoring-division step, settles quotient bit BIT.
// Depends on vtp_pkg.
`default_nettype none
module vtp_div_stage
    import vtp_pkg::*;
#(
    parameter int BIT = 0
) (
    input  wire                 i_clk,
    input  wire [MAG_W-1:0]     i_rem,
    input  wire [T_W-1:0]       i_den,
    input  wire [Q_W-1:0]       i_q,
    input  wire t_div_ctl       i_ctl,
    output logic [MAG_W-1:0]    o_rem,
    output logic [T_W-1:0]      o_den,
    output logic [Q_W-1:0]      o_q,
    output t_div_ctl            o_ctl
);

    logic [CMP_W-1:0] sh;
    logic             fits;

    assign sh   = CMP_W'(i_den) << BIT;
    assign fits = CMP_W'(i_rem) >= sh;

    always_ff @(posedge i_clk) begin
        o_rem <= fits ? MAG_W'(CMP_W'(i_rem) - sh) : i_rem;
        o_q   <= i_q | (Q_W'(fits) << BIT);
        o_den <= i_den;
        o_ctl <= i_ctl;
    end

endmodule
`default_nettype wire

FILE: rtl/core/vtp_div_lane.sv
// vtp_div_lane: perspective divide of one coordinate by w', with clamping.
// Depends on vtp_pkg and vtp_div_stage.
`default_nettype none
module vtp_div_lane
    import vtp_pkg::*;
(
    input  wire                     i_clk,
    input  wire signed [T_W-1:0]    i_t,
    input  wire signed [T_W-1:0]    i_w,
    output logic signed [PT_W-1:0]  o_res,
    output t_lane_flags             o_flags
);

    logic [T_W-1:0]   mag_t, mag_w;
    logic             wz;
    logic [MAG_W-1:0] r_num;
    logic [T_W-1:0]   r_den_a;
    logic             r_neg_a, r_wz_a;

    assign wz    = (i_w == '0);
    assign mag_t = i_t[T_W-1] ? T_W'(-i_t) : T_W'(i_t);
    assign mag_w = i_w[T_W-1] ? T_W'(-i_w) : T_W'(i_w);

    // zero w: divide |x'| by one so the same path passes it through
    always_ff @(posedge i_clk) begin
        r_num   <= wz ? MAG_W'(mag_t) : (MAG_W'(mag_t) << 16);
        r_den_a <= wz ? T_W'(1) : mag_w;
        r_neg_a <= i_t[T_W-1] ^ (i_w[T_W-1] & ~wz);
        r_wz_a  <= wz;
    end

    logic [MAG_W-1:0] rem_c [Q_W+1];
    logic [T_W-1:0]   den_c [Q_W+1];
    logic [Q_W-1:0]   q_c   [Q_W+1];
    t_div_ctl         ctl_c [Q_W+1];

    // quotient too big for 32 bits: saturates whatever the sign
    always_ff @(posedge i_clk) begin
        rem_c[0]     <= r_num;
        den_c[0]     <= r_den_a;
        q_c[0]       <= '0;
        ctl_c[0].neg <= r_neg_a;
        ctl_c[0].wz  <= r_wz_a;
        ctl_c[0].ovf <= CMP_W'(r_num) >= (CMP_W'(r_den_a) << Q_W);
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        vtp_div_stage #(.BIT(Q_W - 1 - k)) u_stage (
            .i_clk (i_clk),
            .i_rem (rem_c[k]),
            .i_den (den_c[k]),
            .i_q   (q_c[k]),
            .i_ctl (ctl_c[k]),
            .o_rem (rem_c[k+1]),
            .o_den (den_c[k+1]),
            .o_q   (q_c[k+1]),
            .o_ctl (ctl_c[k+1])
        );
    end

    logic [Q_W-1:0]          q;
    t_div_ctl                ctl;
    logic signed [PT_W-1:0]  n_res;
    logic                    n_sat;

    assign q   = q_c[Q_W];
    assign ctl = ctl_c[Q_W];

    always_comb begin
        n_sat = 1'b0;
        n_res = $signed(q);
        if (ctl.neg) begin
            if (ctl.ovf || (q > Q_W'(33'h0_8000_0000))) begin
                n_sat = 1'b1;
                n_res = Q_MIN;
            end else begin
                n_res = $signed(-q);
            end
        end else if (ctl.ovf || q[Q_W-1]) begin
            n_sat = 1'b1;
            n_res = Q_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res       <= n_res;
        o_flags.sat <= n_sat;
        o_flags.wz  <= ctl.wz;
    end

endmodule
`default_nettype wire

FILE: tb/vertex_transform_perspective_tb.sv
// vertex_transform_perspective_tb: self-checking bench for the vertex transform.
// Drives points and matrix rows, predicts each result and scores it in order.
// Depends on vtp_pkg and the vertex_transform_perspective RTL.
`timescale 1ns / 1ps

// Holds the matrix copy and the queue of predicted transformed points.
class vtp_point_scoreboard;
    typedef struct {
        logic [31:0] px, py, pz;
        logic        wz, sat;
    } t_point_res;

    logic [63:0] rows [4];
    t_point_res  pending [$];
    int          errors;

    function new();
        rows[0] = vtp_pkg::ROW0_RST;
        rows[1] = vtp_pkg::ROW1_RST;
        rows[2] = vtp_pkg::ROW2_RST;
        rows[3] = vtp_pkg::ROW3_RST;
        errors  = 0;
    endfunction

    function void write_row(logic [2:0] idx, logic [63:0] val);
        if (idx < 3'd4) rows[idx] = val;
    endfunction

    function logic signed [15:0] coef(int r, int c);
        return rows[r][16*c +: 16];
    endfunction

    // point times matrix, reduce, divide, clamp
    function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
        logic signed [63:0] acc, t [4], v;
        logic signed [127:0] wide;
        t_point_res r;
        r.sat = 1'b0;
        for (int c = 0; c < 4; c++) begin
            acc = 64'(x) * 64'(coef(0, c)) + 64'(y) * 64'(coef(1, c))
                + 64'(z) * 64'(coef(2, c)) + (64'(coef(3, c)) <<< 16);
            t[c] = acc >>> 12;
        end
        r.wz = (t[3] == 0);
        for (int k = 0; k < 3; k++) begin
            v = t[k];
            if (!r.wz) begin
                wide = (128'(v) <<< 16) / 128'(t[3]);
                v = wide[63:0];
            end
            if (v > 64'sd2147483647) begin
                v = 64'sd2147483647; r.sat = 1'b1;
            end else if (v < -64'sd2147483648) begin
                v = -64'sd2147483648; r.sat = 1'b1;
            end
            if (k == 0) r.px = v[31:0];
            else if (k == 1) r.py = v[31:0];
            else r.pz = v[31:0];
        end
        pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %s got %h want %h", what, got, want);
        errors++;
    endtask

    task check_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                     logic wz, logic sat);
        t_point_res e;
        if (pending.size() == 0) begin
            report("unexpected result", x, 0);
            return;
        end
        e = pending.pop_front();
        if (x !== e.px) report("out_x", x, e.px);
        if (y !== e.py) report("out_y", y, e.py);
        if (z !== e.pz) report("out_z", z, e.pz);
        if (wz !== e.wz) report("w_zero", wz, e.wz);
        if (sat !== e.sat) report("saturated", sat, e.sat);
    endtask
endclass

module vertex_transform_perspective_tb;
    import vtp_pkg::*;

    localparam int LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_ROW0;
    logic [ROW_W-1:0] i_cfg_data = '0;
    logic o_valid;
    logic signed [31:0] o_out_x, o_out_y, o_out_z;
    logic o_w_zero, o_saturated;

    vtp_point_scoreboard sb = new();
    int cycles = 0;
    bit calm = 1'b0;   // no idling while set

    vertex_transform_perspective dut (.*);

    initial forever #1 i_clk = ~i_clk;

    // results cannot be held off: score every strobe
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid)
            sb.check_point(o_out_x, o_out_y, o_out_z, o_w_zero, o_saturated);
        if (cycles > LIMIT) begin
            $display("vertex_transform_perspective: mismatch");
            $finish;
        end
    end

    // one point; start stays high across back-to-back items
    task send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (!calm) while ($urandom_range(99) < 29) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_in_x <= x;
        i_in_y <= y;
        i_in_z <= z;
        do @(posedge i_clk); while (busy);
        sb.note_point(x, y, z);
    endtask

    task end_burst();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every outstanding result, then let the pipe settle before the next phase
    task drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task write_row(logic [2:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_row(idx, val);
        @(posedge i_clk);
    endtask

    function logic [31:0] rnd_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            default: return $urandom();
        endcase
    endfunction

    // rows: mostly sane Q4.12 values, sometimes full-range
    function logic [15:0] rnd_coef(bit wild);
        if (wild || $urandom_range(3) == 0) return 16'($urandom());
        return 16'($urandom_range(16'h2000) - 16'h1000);
    endfunction

    task load_matrix(int mode);
        logic [63:0] r;
        for (int i = 0; i < 4; i++) begin
            case (mode)
                0: r = 64'h0000_0000_0000_1000 << (16 * i);        // identity
                1: r = {4{16'h7FFF}};
                2: r = {4{16'h8000}};
                3: r = (i == 3) ? 64'h0 : {$urandom(), $urandom()}; // translation row zero
                default: r = {rnd_coef(0), rnd_coef(0), rnd_coef(0), rnd_coef(0)};
            endcase
            write_row(3'(i), r);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, extremes, zero w, overflow
        calm = 1'b1;
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
        end_burst();
        drain();
        write_row(CFG_ROW3, 64'h0);          // w' zero for every point
        send_point(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF);
        end_burst();
        drain();
        write_row(CFG_ROW3, 64'h0001_0000_0000_0000); // tiny w: divide overflows
        write_row(CFG_ROW0, 64'h0000_7FFF_7FFF_7FFF);
        send_point(32'h7FFF_FFFF, 32'h0, 32'h0);
        send_point(32'h8000_0000, 32'h0, 32'h0);
        send_point(32'h0000_0100, 32'h0, 32'h0);
        end_burst();
        drain();
        write_row(3'd7, 64'hDEAD_BEEF_DEAD_BEEF); // ignored index
        for (int m = 0; m < 4; m++) begin
            load_matrix(m);
            send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
            send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
            send_point($urandom(), $urandom(), $urandom());
            end_burst();
            drain();
        end

        // random phases with a new matrix each time
        for (int ph = 0; ph < 25; ph++) begin
            calm = (ph == 3);
            load_matrix((ph % 6 == 5) ? $urandom_range(3) : 4);
            repeat (50) send_point(rnd_coord(), rnd_coord(), rnd_coord());
            end_burst();
            drain();
        end
        load_matrix(0);

        if (sb.errors == 0)
            $display("vertex_transform_perspective: match");
        else
            $display("vertex_transform_perspective: mismatch");
        $finish;
    end
endmodule

FILE: vertex_transform_perspective.f
rtl/core/vtp_pkg.sv
rtl/core/vtp_xform.sv
rtl/core/vtp_div_stage.sv
rtl/core/vtp_div_lane.sv
rtl/core/vertex_transform_perspective.sv
tb/vertex_transform_perspective_tb.sv
